/* rtl/skgf_pkg.sv */
// Shared types and constants for the scalar Kalman gyro filter.
// No dependencies; imported by the divider, the top level and the checker.
package skgf_pkg;

  // Reset values of the noise registers, unsigned Q16.16 (about 0.02 and 0.1).
  localparam logic [31:0] PN_RESET = 32'd1311;
  localparam logic [31:0] MN_RESET = 32'd6554;

  // Gain of exactly 1.0 in Q1.16.
  localparam logic [16:0] K_ONE = 17'h10000;

  // Quotient bits produced by the divider, one per cycle.
  localparam int DIV_STEPS = 17;

  // Configuration register indexes.
  typedef enum logic {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEASURE_NOISE = 1'b1
  } cfg_reg_t;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PRED   = 7'b0000010,
    ST_DSTART = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_MUL1   = 7'b0010000,
    ST_MUL2   = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  // Status returned by the gain divider.
  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_stat_t;

endpackage

/* rtl/skgf_div.sv */
// Restoring divider for the Kalman gain: floor(num * 65536 / den), num <= den.
// Depends on skgf_pkg (div_stat_t, DIV_STEPS).
module skgf_div
  import skgf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [32:0] den,
  output div_stat_t   stat
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [33:0]      rem;
  logic [16:0]      quot;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;

  logic [34:0] diff;
  logic        qbit;
  logic [33:0] rem_keep;

  // The remainder always stays below twice the divisor, so 34 bits hold it.
  assign diff     = {1'b0, rem} - {2'b00, den};
  assign qbit     = ~diff[34];
  assign rem_keep = qbit ? diff[33:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {2'b00, num};
      quot <= '0;
    end else if (run) begin
      rem  <= {rem_keep[32:0], 1'b0};
      quot <= {quot[15:0], qbit};
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

/* rtl/scalar_kalman_gyro_filter.sv */
// Top level of the per-axis scalar Kalman gyro filter.
// Depends on skgf_pkg and skgf_div.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  s_       | s_tvalid / s_tready     | tdata: sample; tuser: axis
//  m_       | m_tvalid / m_tready     | tdata: estimate; tuser: axis_out
//  cfg_     | cfg_wen                 | cfg_index, cfg_data
//
// A valid-axis item goes through prediction, the gain division and the multiply
// steps before its result is offered; an item on an axis at or above CHANNELS
// skips them and is passed through unchanged. Reset is synchronous and clears
// the noise registers to defaults and every estimate and covariance to zero.
// A finished result waits in the output register; if it has not been taken
// when the next one is ready, the sequencer holds until the slot frees.
module scalar_kalman_gyro_filter
  import skgf_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic [1:0]  s_tuser,   // [1:0] axis
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] estimate
  output logic [1:0]  m_tuser,   // [1:0] axis_out
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state;

  logic [31:0] process_noise;
  logic [31:0] measure_noise;
  logic [31:0] axis_estimate   [CHANNELS];
  logic [31:0] axis_covariance [CHANNELS];

  logic [31:0]      samp_r;
  logic [1:0]       axis_r;
  logic [IDX_W-1:0] ch_r;
  logic             hit_r;
  logic [31:0]      pt_r;
  logic [32:0]      den_r;
  logic [31:0]      est_r;
  logic [32:0]      err_r;
  logic [16:0]      k_r;
  logic signed [51:0] prod_r;
  logic [31:0]      xn_r;

  logic             accept;
  logic             out_free;
  logic [IDX_W+1:0] ax_ext;
  logic             ax_hit;
  logic [32:0]      cov_sum;
  logic [31:0]      pt_next;
  logic [31:0]      est_sel;
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [35:0] xsum;
  logic [31:0]      xn_next;
  logic             div_start;
  div_stat_t        div_stat;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  assign ax_ext = {{IDX_W{1'b0}}, s_tuser};
  assign ax_hit = ({30'd0, s_tuser} < 32'(CHANNELS));

  // Prediction: covariance plus process noise, held at full scale on overflow.
  assign cov_sum = {1'b0, axis_covariance[ch_r]} + {1'b0, process_noise};
  assign pt_next = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
  assign est_sel = axis_estimate[ch_r];

  // One multiplier serves both the estimate step and the covariance update.
  always_comb begin
    if (state == ST_MUL1) begin
      mul_a = $signed({1'b0, k_r});
      mul_b = $signed({err_r[32], err_r});
    end else begin
      mul_a = $signed({1'b0, K_ONE - k_r});
      mul_b = $signed({2'b00, pt_r});
    end
  end

  // The arithmetic shift of K * e floors toward minus infinity.
  assign xsum = $signed({{4{est_r[31]}}, est_r}) + $signed(prod_r[51:16]);

  always_comb begin
    if (xsum[35:31] == 5'b00000 || xsum[35:31] == 5'b11111) begin
      xn_next = xsum[31:0];
    end else if (xsum[35]) begin
      xn_next = 32'h8000_0000;
    end else begin
      xn_next = 32'h7FFF_FFFF;
    end
  end

  assign div_start = (state == ST_DSTART);

  skgf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pt_r),
    .den   (den_r),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PN_RESET;
      measure_noise <= MN_RESET;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROCESS_NOISE: process_noise <= cfg_data;
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        axis_estimate[i]   <= '0;
        axis_covariance[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ax_hit ? ST_PRED : ST_FIN;
          end
        end
        ST_PRED:   state <= ST_DSTART;
        ST_DSTART: state <= ST_DIV;
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_MUL1;
          end
        end
        ST_MUL1:   state <= ST_MUL2;
        ST_MUL2:   state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (hit_r) begin
              axis_estimate[ch_r]   <= xn_r;
              axis_covariance[ch_r] <= prod_r[47:16];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          samp_r <= s_tdata;
          axis_r <= s_tuser;
          ch_r   <= ax_ext[IDX_W-1:0];
          hit_r  <= ax_hit;
          xn_r   <= s_tdata;
        end
      end
      ST_PRED: begin
        pt_r  <= pt_next;
        den_r <= {1'b0, pt_next} + {1'b0, measure_noise};
        est_r <= est_sel;
        err_r <= {samp_r[31], samp_r} - {est_sel[31], est_sel};
      end
      ST_DIV: begin
        if (div_stat.done) begin
          // A zero denominator (predicted covariance and measurement noise both zero) gives a zero gain.
          k_r <= (den_r == 33'd0) ? 17'd0 : div_stat.quot;
        end
      end
      ST_MUL1: begin
        prod_r <= mul_a * mul_b;
      end
      ST_MUL2: begin
        prod_r <= mul_a * mul_b;
        xn_r   <= xn_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= xn_r;
      m_tuser <= axis_r;
    end
  end

endmodule

/* rtl/skgf_checker.sv */
// Port-level checks for scalar_kalman_gyro_filter, bound to the top level.
// Depends on skgf_pkg and the top-level port list.
module skgf_checker
  import skgf_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic [1:0]  last_axis;
  logic [31:0] last_sample;
  logic        last_miss;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      last_axis   <= s_tuser;
      last_sample <= s_tdata;
    end
  end

  assign last_miss = ({30'd0, last_axis} >= 32'(CHANNELS));

  // A result waiting at the output stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped before it was taken");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again while an item is in work");

  // A new result carries the axis of the item just accepted.
  a_axis_match: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tuser == last_axis))
    else $error("result axis does not match the accepted item");

  // An item on an unknown axis comes back unchanged.
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && last_miss) |-> (m_tdata == last_sample))
    else $error("out-of-range axis item was altered");

endmodule

bind scalar_kalman_gyro_filter skgf_checker #(
  .CHANNELS (CHANNELS)
) u_skgf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
